[rtl/swm_pkg.sv]
package swm_pkg;

  localparam int unsigned WINDOW_MAX = 64;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned CFG_W      = 7;
  // Ages run up to WINDOW_MAX, so one bit more than an index is needed.
  localparam int unsigned AGE_W      = $clog2(WINDOW_MAX + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [AGE_W-1:0]           age_t;

  // One queue entry as held by a cell.
  typedef struct packed {
    logic    valid;
    sample_t value;
    age_t    age;
  } cell_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic    step;
    logic    pop;
    logic    shift;
    logic    flush;
    sample_t sample;
    age_t    window;
  } ctl_t;

  localparam cell_t CELL_EMPTY = '{valid: 1'b0, value: '0, age: '0};

  // Window size as used: zero counts as one, anything above the row length saturates.
  function automatic age_t eff_window(input logic [CFG_W-1:0] ws);
    age_t w;
    if (ws == '0) begin
      w = age_t'(1);
    end else if (AGE_W'(ws) > age_t'(WINDOW_MAX)) begin
      w = age_t'(WINDOW_MAX);
    end else begin
      w = AGE_W'(ws);
    end
    return w;
  endfunction

endpackage

[rtl/swm_in_if.sv]
interface swm_in_if;
  import swm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    first_of_sequence;

  modport source (output valid, sample, first_of_sequence, input ready);
  modport sink   (input valid, sample, first_of_sequence, output ready);
endinterface

[rtl/swm_out_if.sv]
interface swm_out_if;
  import swm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t window_max;

  modport source (output valid, window_max, input ready);
  modport sink   (input valid, window_max, output ready);
endinterface

[rtl/swm_cell.sv]
module swm_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  swm_pkg::ctl_t  ctl_i,
  input  swm_pkg::cell_t right_i,
  input  logic           right_keep_i,
  input  logic           left_keep_i,
  output swm_pkg::cell_t state_o,
  output logic           keep_o,
  output logic           src_keep_o
);
  import swm_pkg::*;

  logic    valid_q, valid_d;
  sample_t value_q, value_d;
  age_t    age_q, age_d;
  cell_t   src;
  age_t    age_inc;

  assign state_o = '{valid: valid_q, value: value_q, age: age_q};
  assign age_inc = age_q + age_t'(1);

  // An entry survives when no flush is on, it is still inside the window and it is not below the new word.
  assign keep_o = valid_q && !ctl_i.flush && (age_inc < ctl_i.window) &&
                  !($signed(value_q) < $signed(ctl_i.sample));

  assign src        = ctl_i.shift ? right_i : state_o;
  assign src_keep_o = ctl_i.shift ? right_keep_i : keep_o;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    age_d   = age_q;
    if (ctl_i.pop) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
      age_d   = right_i.age;
    end else if (ctl_i.step) begin
      if (src_keep_o) begin
        valid_d = 1'b1;
        value_d = src.value;
        age_d   = src.age + age_t'(1);
      end else if (left_keep_i) begin
        // First free place behind the survivors takes the new word.
        valid_d = 1'b1;
        value_d = ctl_i.sample;
        age_d   = '0;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

endmodule

[rtl/sliding_window_maximum.sv]
// Sliding window maximum over a stream of signed words.
// in_i carries one word per handshake (sample and first_of_sequence); out_o
// returns window_max, the largest of the last window_size words, once that
// many words have arrived since the start of a sequence. Earlier words give
// no result. first_of_sequence empties the window before its word is taken.
// window_size is written through cfg_we_i/cfg_data_i, by the user only while
// the block is idle, which the block does not enforce; zero acts as one and
// values above 64 act as 64. A word's result is registered and is on out_o
// the cycle after the word is taken, so the block sustains one word per cycle
// while out_o takes results and no expired front entry is pending. The queue
// is a row of 64 cells, front in cell 0; each cell ages, drops or hands its
// entry to its neighbour. Only after the window has been shrunk can more than
// one entry expire at once: then each further expired front entry is dropped
// on its own while in_i.ready is low. Reset empties the queue, clears the word
// count and sets window_size to 1. A stalled result is held in the output
// register; in_i.ready is low while that register is full and not being emptied.
module sliding_window_maximum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0] cfg_data_i,
  swm_in_if.sink                    in_i,
  swm_out_if.source                 out_o
);
  import swm_pkg::*;

  logic [CFG_W-1:0] win_size_q;
  age_t             seen_q, seen_d;
  age_t             window;
  age_t             seen_base, seen_inc;
  logic             out_valid_q;
  sample_t          out_max_q;
  logic             need_pop, step, has_result;
  ctl_t             ctl;
  cell_t            cells    [WINDOW_MAX];
  logic             keep     [WINDOW_MAX];
  logic             src_keep [WINDOW_MAX];
  cell_t            src0;
  sample_t          front_d;

  assign window = eff_window(win_size_q);

  // Cell 1 can only have expired after a shrink; drop the front first then.
  assign need_pop   = cells[1].valid && ((cells[1].age + age_t'(1)) >= window);
  assign in_i.ready = (!out_valid_q || out_o.ready) && !need_pop;
  assign step       = in_i.valid && in_i.ready;

  assign ctl.step   = step;
  assign ctl.pop    = in_i.valid && need_pop;
  assign ctl.flush  = in_i.first_of_sequence;
  assign ctl.shift  = cells[0].valid && !in_i.first_of_sequence &&
                      ((cells[0].age + age_t'(1)) >= window);
  assign ctl.sample = in_i.sample;
  assign ctl.window = window;

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    cell_t right;
    logic  right_keep;
    logic  left_keep;
    if (j == WINDOW_MAX - 1) begin : g_last
      assign right      = CELL_EMPTY;
      assign right_keep = 1'b0;
    end else begin : g_mid
      assign right      = cells[j+1];
      assign right_keep = keep[j+1];
    end
    if (j == 0) begin : g_first
      assign left_keep = 1'b1;
    end else begin : g_rest
      assign left_keep = src_keep[j-1];
    end
    swm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .right_i      (right),
      .right_keep_i (right_keep),
      .left_keep_i  (left_keep),
      .state_o      (cells[j]),
      .keep_o       (keep[j]),
      .src_keep_o   (src_keep[j])
    );
  end

  // Front of the queue after this word goes in.
  assign src0    = ctl.shift ? cells[1] : cells[0];
  assign front_d = src_keep[0] ? src0.value : in_i.sample;

  assign seen_base  = in_i.first_of_sequence ? '0 : seen_q;
  assign seen_inc   = seen_base + age_t'(1);
  assign seen_d     = (seen_inc >= window) ? window : seen_inc;
  assign has_result = (seen_inc >= window);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q  <= CFG_W'(1);
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_size_q <= cfg_data_i;
      end
      if (step) begin
        seen_q <= seen_d;
      end
      if (step && has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && has_result) begin
      out_max_q <= front_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.window_max = out_max_q;

endmodule

[test/sliding_window_maximum_tb.sv]
module sliding_window_maximum_tb;
  import swm_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RANDOM_WORDS = 1850;
  localparam int unsigned SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [CFG_W-1:0] win;
    sample_t          sample;
    logic             first;
    logic             typed;
    sample_t          want;
  } dir_row_t;

  typedef struct {
    bit      typed;
    sample_t value;
  } max_note_t;

  localparam sample_t S_MIN = 32'sh8000_0000;
  localparam sample_t S_MAX = 32'sh7fff_ffff;

  // Short directed sequence; expected maxima are typed in where they are obvious.
  localparam dir_row_t DIR_ROWS [22] = '{
    '{7'd1, S_MIN,    1'b1, 1'b1, S_MIN},
    '{7'd1, S_MAX,    1'b0, 1'b1, S_MAX},
    '{7'd1, 32'sd0,   1'b0, 1'b1, 32'sd0},
    '{7'd1, -32'sd1,  1'b0, 1'b1, -32'sd1},
    '{7'd0, 32'sd12345, 1'b0, 1'b1, 32'sd12345},
    '{7'd0, -32'sd7,  1'b1, 1'b1, -32'sd7},
    '{7'd3, 32'sd5,   1'b1, 1'b0, 32'sd0},
    '{7'd3, -32'sd2,  1'b0, 1'b0, 32'sd0},
    '{7'd3, 32'sd7,   1'b0, 1'b1, 32'sd7},
    '{7'd3, 32'sd7,   1'b0, 1'b1, 32'sd7},
    '{7'd3, 32'sd1,   1'b0, 1'b1, 32'sd7},
    '{7'd3, 32'sd1,   1'b0, 1'b1, 32'sd7},
    '{7'd3, 32'sd0,   1'b0, 1'b0, 32'sd0},
    '{7'd3, S_MIN,    1'b1, 1'b0, 32'sd0},
    '{7'd3, S_MIN,    1'b0, 1'b0, 32'sd0},
    '{7'd3, S_MAX,    1'b0, 1'b1, S_MAX},
    '{7'd4, 32'sd9,   1'b1, 1'b0, 32'sd0},
    '{7'd4, 32'sd8,   1'b0, 1'b0, 32'sd0},
    '{7'd4, 32'sd7,   1'b0, 1'b0, 32'sd0},
    '{7'd4, 32'sd6,   1'b0, 1'b1, 32'sd9},
    '{7'd1, -32'sd5,  1'b0, 1'b1, -32'sd5},
    '{7'd2, 32'sd3,   1'b0, 1'b0, 32'sd0}
  };

  localparam int unsigned SPECIAL_WIN [6] = '{127, 64, 65, 2, 0, 1};

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_data_i;

  swm_in_if  in_if ();
  swm_out_if out_if ();

  sliding_window_maximum u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Predictor state, kept in step with the words the block accepts.
  sample_t          cand_val [WINDOW_MAX];
  int               cand_age [WINDOW_MAX];
  int               cand_cnt;
  int               seen_cnt;
  logic [CFG_W-1:0] win_reg;
  int               deepest;

  max_note_t note_q [$];
  sample_t   pending_max [$];

  int unsigned errors;
  int unsigned words_in;
  int unsigned maxima_checked;
  int unsigned cfg_writes;
  bit          calm;
  sample_t     ramp;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    #8000000;
    $display("simulation timed out");
    $display("TB_ERROR");
    $finish;
  end

  // Takes one word into the window and reports the maximum, if one is due.
  function automatic bit slide_window(input sample_t s, input logic first,
                                      output sample_t front);
    int w;
    int kept;
    w = int'(win_reg);
    if (w < 1) w = 1;
    if (w > int'(WINDOW_MAX)) w = int'(WINDOW_MAX);
    if (first) begin
      cand_cnt = 0;
      seen_cnt = 0;
    end
    kept = 0;
    for (int i = 0; i < cand_cnt; i++) begin
      if (cand_age[i] + 1 >= w) continue;
      if (cand_val[i] < s) continue;
      cand_val[kept] = cand_val[i];
      cand_age[kept] = cand_age[i] + 1;
      kept++;
    end
    if (kept < int'(WINDOW_MAX)) begin
      cand_val[kept] = s;
      cand_age[kept] = 0;
      kept++;
    end
    cand_cnt = kept;
    if (kept > deepest) deepest = kept;
    seen_cnt = (seen_cnt + 1 >= w) ? w : seen_cnt + 1;
    front = cand_val[0];
    return seen_cnt >= w;
  endfunction

  function automatic void log_error(input string msg);
    errors++;
    if (errors <= SHOW_LIMIT) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin : scoreboard
    max_note_t note;
    sample_t   front;
    sample_t   want;
    bit        due;
    if (!rst_ni) begin
      cand_cnt = 0;
      seen_cnt = 0;
      win_reg  = 7'd1;
    end else begin
      if (cfg_we_i) win_reg = cfg_data_i;
      if (in_if.valid && in_if.ready) begin
        note = note_q.pop_front();
        due  = slide_window(in_if.sample, in_if.first_of_sequence, front);
        if (note.typed) pending_max.insert(pending_max.size(), note.value);
        else if (due) pending_max.insert(pending_max.size(), front);
        words_in++;
      end
      if (out_if.valid && out_if.ready) begin
        maxima_checked++;
        if (pending_max.size() == 0) begin
          log_error($sformatf("unexpected window_max %0d", out_if.window_max));
        end else begin
          want = pending_max.pop_front();
          if (out_if.window_max !== want)
            log_error($sformatf("window_max mismatch: expected %0d, got %0d",
                                want, out_if.window_max));
        end
      end
    end
  end

  // Result side: mostly short stalls, now and then a long one.
  initial begin : sink_stalls
    int unsigned hold;
    int unsigned r;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if (calm) begin
        out_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_if.ready <= 1'b1;
          hold = $urandom_range(0, 7);
        end else if (r < 95) begin
          out_if.ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          out_if.ready <= 1'b0;
          hold = $urandom_range(10, 50);
        end
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return sample_t'($urandom);
    case (mode)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(0, 8)) - 32'sd4;
      2: begin
        // A falling ramp with repeats fills the candidate queue.
        ramp = ramp - sample_t'($urandom_range(0, 2));
        return ramp;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: return S_MIN;
          1: return S_MAX;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Holds the valid high until the word has been taken.
  task automatic send_word(input sample_t s, input logic first, input bit typed,
                           input sample_t want);
    note_q.insert(note_q.size(), max_note_t'{typed, want});
    in_if.valid             <= 1'b1;
    in_if.sample            <= s;
    in_if.first_of_sequence <= first;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic idle_for(input int unsigned n);
    if (n != 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Waits until every maximum has come back and the block has settled.
  task automatic quiesce();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_max.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input int unsigned w);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= CFG_W'(w);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  initial begin : stimulus
    int unsigned cur_win;
    int unsigned win;
    int unsigned eff;
    int unsigned mode;
    int unsigned phase_len;
    int unsigned phase;
    int unsigned rand_words;
    logic        first;
    errors         = 0;
    words_in       = 0;
    maxima_checked = 0;
    cfg_writes     = 0;
    deepest        = 0;
    calm           = 1'b0;
    ramp           = '0;
    rst_ni                  <= 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_data_i              <= '0;
    in_if.valid             <= 1'b0;
    in_if.sample            <= '0;
    in_if.first_of_sequence <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_win = 1;
    foreach (DIR_ROWS[i]) begin
      if (int'(DIR_ROWS[i].win) != cur_win) begin
        quiesce();
        write_window(DIR_ROWS[i].win);
        cur_win = DIR_ROWS[i].win;
      end
      send_word(DIR_ROWS[i].sample, DIR_ROWS[i].first, DIR_ROWS[i].typed,
                DIR_ROWS[i].want);
      idle_for(gap_len());
    end

    // Random phases; a phase need not start a new sequence, so the window
    // often changes in the middle of one.
    phase      = 0;
    rand_words = 0;
    while (rand_words < RANDOM_WORDS) begin
      if (phase < 6) begin
        win = SPECIAL_WIN[phase];
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    win = $urandom_range(9, 64);
          2:       win = $urandom_range(65, 127);
          default: win = $urandom_range(1, 8);
        endcase
      end
      quiesce();
      write_window(win);
      calm      = ($urandom_range(0, 4) == 0);
      mode      = $urandom_range(0, 3);
      ramp      = sample_t'($urandom);
      eff       = (win == 0) ? 1 : ((win > WINDOW_MAX) ? WINDOW_MAX : win);
      phase_len = $urandom_range(10, 60) + 2 * eff;
      for (int k = 0; k < phase_len; k++) begin
        if (k == 0) first = $urandom_range(0, 1);
        else first = ($urandom_range(0, 39) == 0);
        send_word(pick_sample(mode), first, 1'b0, '0);
        idle_for(gap_len());
        rand_words++;
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_max.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d words sent, %0d window maxima checked, %0d window writes over %0d phases",
             words_in, maxima_checked, cfg_writes, phase);
    $display("deepest candidate queue reached %0d of %0d, %0d mismatches",
             deepest, WINDOW_MAX, errors);
    if (errors == 0 && pending_max.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
